@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked from the first edge after reset is released
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

@@ rtl/core/sks_pkg.sv @@
`default_nettype none

package sks_pkg;

  localparam int OPC_W = 2;
  localparam int KEY_W = 32;
  localparam int STS_W = 2;
  localparam int POS_W = 6;
  localparam int CNT_W = 7;

  localparam logic [OPC_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OPC_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OPC_W-1:0] OP_LOOKUP = 2'd2;

  localparam logic [STS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STS_W-1:0] ST_NOEFFECT = 2'd1;
  localparam logic [STS_W-1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic [OPC_W-1:0] opcode;
    logic [KEY_W-1:0] key;
  } in_word_t;

  typedef struct packed {
    logic [STS_W-1:0] status;
    logic [POS_W-1:0] position;
    logic [CNT_W-1:0] member_count;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request, open search window
    logic srch_rd;   // read entry at search midpoint
    logic srch_upd;  // narrow search window
    logic mv_init;   // set up entry shift
    logic mv_rd;     // read source entry of shift
    logic mv_wr;     // write it one place over
    logic put;       // write new key at its place
    logic respond;   // update count, drive result
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic srch_done;
    logic do_move;
    logic mv_done;
    logic is_insert;
  } ctrl_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/sks_ctrl.sv @@
`default_nettype none

`include "assert_macros.svh"

module sks_ctrl
  import sks_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire ctrl_sts_t sts,
  output ctrl_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SRD  = 3'd1;
  localparam logic [2:0] S_SCMP = 3'd2;
  localparam logic [2:0] S_DEC  = 3'd3;
  localparam logic [2:0] S_MCHK = 3'd4;
  localparam logic [2:0] S_MWR  = 3'd5;
  localparam logic [2:0] S_PUT  = 3'd6;
  localparam logic [2:0] S_RESP = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_SRD;
        end
      end
      S_SRD: begin
        if (sts.srch_done) begin
          state_nxt = S_DEC;
        end else begin
          cmd.srch_rd = 1'b1;
          state_nxt   = S_SCMP;
        end
      end
      S_SCMP: begin
        cmd.srch_upd = 1'b1;
        state_nxt    = S_SRD;
      end
      S_DEC: begin
        if (sts.do_move) begin
          cmd.mv_init = 1'b1;
          state_nxt   = S_MCHK;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_MCHK: begin
        if (sts.mv_done) begin
          state_nxt = sts.is_insert ? S_PUT : S_RESP;
        end else begin
          cmd.mv_rd = 1'b1;
          state_nxt = S_MWR;
        end
      end
      S_MWR: begin
        cmd.mv_wr = 1'b1;
        state_nxt = S_MCHK;
      end
      S_PUT: begin
        cmd.put   = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        cmd.respond = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  `ASSERT_RST(a_put_only_insert, clk, rst_n, cmd.put |-> sts.is_insert, "key write outside insert")
  `ASSERT_RST(a_accept_goes_busy, clk, rst_n, (start && !busy) |=> busy, "request not taken")

endmodule

`default_nettype wire

@@ rtl/core/sks_dp.sv @@
`default_nettype none

`include "assert_macros.svh"

module sks_dp
  import sks_pkg::*;
#(
  parameter int CAPACITY  = 64,
  parameter int KEY_WIDTH = 32
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire in_word_t  in_word,
  input  wire ctrl_cmd_t cmd,
  output ctrl_sts_t      sts,
  output logic           out_valid,
  output out_word_t      out_word
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [KEY_WIDTH-1:0] mem [CAPACITY];

  logic [KEY_WIDTH-1:0] key_r;
  logic [OPC_W-1:0]     op_r;
  logic [CW-1:0]        lo_r;
  logic [CW-1:0]        hi_r;
  logic                 hit_r;
  logic [CW-1:0]        idx_r;
  logic [CW-1:0]        count_r;
  logic [CW-1:0]        count_nxt;
  logic [KEY_WIDTH-1:0] rdata_r;
  logic                 out_valid_r;
  out_word_t            out_word_r;

  logic [CW:0]          mid_sum;
  logic [CW-1:0]        mid;
  logic [CW-1:0]        idx_dec;
  logic [CW-1:0]        idx_inc;
  logic [AW-1:0]        rd_addr;
  logic                 is_insert;
  logic                 is_remove;
  logic                 full;
  logic [STS_W-1:0]     res_status;
  logic                 res_done;

  assign mid_sum   = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid       = mid_sum[CW:1];
  assign idx_dec   = idx_r - CW'(1);
  assign idx_inc   = idx_r + CW'(1);
  assign is_insert = (op_r == OP_INSERT);
  assign is_remove = (op_r == OP_REMOVE);
  assign full      = (count_r == CW'(CAPACITY));

  always_comb begin
    case (op_r)
      OP_INSERT: res_status = hit_r ? ST_NOEFFECT : (full ? ST_FULL : ST_DONE);
      OP_REMOVE: res_status = hit_r ? ST_DONE : ST_NOEFFECT;
      OP_LOOKUP: res_status = hit_r ? ST_DONE : ST_NOEFFECT;
      default:   res_status = ST_NOEFFECT;
    endcase
  end

  assign res_done = (res_status == ST_DONE);

  always_comb begin
    count_nxt = count_r;
    if (res_done && is_insert) begin
      count_nxt = count_r + CW'(1);
    end else if (res_done && is_remove) begin
      count_nxt = count_r - CW'(1);
    end
  end

  assign sts.srch_done = !(lo_r < hi_r);
  assign sts.do_move   = (is_insert && !hit_r && !full) || (is_remove && hit_r);
  assign sts.mv_done   = is_insert ? (idx_r == lo_r) : !(idx_inc < count_r);
  assign sts.is_insert = is_insert;

  // search reads the midpoint; a shift reads the neighbor of the target slot
  assign rd_addr = cmd.srch_rd ? mid[AW-1:0] : (is_insert ? idx_dec[AW-1:0] : idx_inc[AW-1:0]);

  always_ff @(posedge clk) begin
    if (cmd.srch_rd || cmd.mv_rd) begin
      rdata_r <= mem[rd_addr];
    end
    if (cmd.mv_wr) begin
      mem[idx_r[AW-1:0]] <= rdata_r;
    end else if (cmd.put) begin
      mem[idx_r[AW-1:0]] <= key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= KEY_WIDTH'(in_word.key);
      op_r  <= in_word.opcode;
      lo_r  <= '0;
      hi_r  <= count_r;
      hit_r <= 1'b0;
    end else if (cmd.srch_upd) begin
      if (rdata_r < key_r) begin
        lo_r <= mid + CW'(1);
      end else begin
        // hit tracks the entry at hi, which ends up as the key's place
        hi_r  <= mid;
        hit_r <= (rdata_r == key_r);
      end
    end
    if (cmd.mv_init) begin
      idx_r <= is_insert ? count_r : lo_r;
    end else if (cmd.mv_wr) begin
      idx_r <= is_insert ? idx_dec : idx_inc;
    end
    if (cmd.respond) begin
      out_word_r.status       <= res_status;
      out_word_r.position     <= res_done ? POS_W'(lo_r) : '0;
      out_word_r.member_count <= CNT_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.respond;
      if (cmd.respond) begin
        count_r <= count_nxt;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `ASSERT_RST(a_count_bound, clk, rst_n, count_r <= CW'(CAPACITY), "key count above capacity")
  `ASSERT_RST(a_single_strobe, clk, rst_n, out_valid_r |=> !out_valid_r, "result strobe held")
  `ASSERT_RST(a_shift_in_range, clk, rst_n, cmd.mv_wr |-> (idx_r < count_r || (is_insert && idx_r == count_r)), "shift outside table")

endmodule

`default_nettype wire

@@ rtl/core/sorted_key_set_top.sv @@
// Channel   Ports                      Transfer
// request   start, busy, in_word       start high while busy low
// result    out_valid, out_word        one-cycle strobe, always taken
//
// One request at a time; busy is high from the accepting edge until the result strobe.
// Search: each halving reads the midpoint and compares; a final check sees the window closed.
// Shift: each moved entry is read and written, and a final check ends it; an insert also places its key.
// Reset clears the count, the result strobe and the controller state; key memory contents need no clearing.
// The result receiver cannot stall; each word is shown for exactly one cycle.
`default_nettype none

module sorted_key_set_top
  import sks_pkg::*;
#(
  parameter int CAPACITY  = 64,
  parameter int KEY_WIDTH = 32
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_word_t in_word,
  output logic          out_valid,
  output out_word_t     out_word
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  sks_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  sks_dp #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire
